@@ rtl/core/nts_pkg.sv @@
// Shared constants, types and codes of the newest-k timestamp sampler.
package nts_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned STAMP_W    = 64;

  typedef logic signed [STAMP_W-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [CAP_W-1:0]          cap_t;

  localparam cap_t CAP_RESET = cap_t'(16);

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic   tok;
    stamp_t stamp;
    slot_t  idx;
  } chain_t;

  // Write strobe broadcast to every cell.
  typedef struct packed {
    logic   en;
    slot_t  idx;
    stamp_t stamp;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/nts_ifs.sv @@
// Valid/ready channel interfaces for records in and decisions out.
interface nts_rec_if import nts_pkg::*; ();
  logic   valid;
  logic   ready;
  stamp_t record_time;

  modport source (output valid, output record_time, input ready);
  modport sink (input valid, input record_time, output ready);
endinterface

interface nts_res_if import nts_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  accepted;
  slot_t slot_index;

  modport source (output valid, output accepted, output slot_index, input ready);
  modport sink (input valid, input accepted, input slot_index, output ready);
endinterface

@@ rtl/core/nts_cell.sv @@
// One slot cell: holds a timestamp and folds it into the passing minimum.
module nts_cell import nts_pkg::*; #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  cap_t   cap,
  input  wr_t    wr,
  input  chain_t link_in,
  output chain_t link_out
);

  localparam cap_t  ID_CAP  = cap_t'(CELL_ID);
  localparam slot_t ID_SLOT = slot_t'(CELL_ID);

  stamp_t slot_time;
  chain_t link_next;

  always_comb begin
    link_next     = link_in;
    // Take this slot when it is in range and strictly older (first cell always).
    if (ID_CAP < cap && (CELL_ID == 0 || slot_time < link_in.stamp)) begin
      link_next.stamp = slot_time;
      link_next.idx   = ID_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == ID_SLOT) begin
      slot_time <= wr.stamp;
    end
  end

  // Advance the token and its running minimum; only the token is reset.
  always_ff @(posedge clk) begin
    link_out.tok   <= rst ? 1'b0 : link_next.tok;
    link_out.stamp <= link_next.stamp;
    link_out.idx   <= link_next.idx;
  end

endmodule

@@ rtl/core/newest_k_timestamp_sampler.sv @@
// Top level of the newest-k timestamp sampler: control and the row of slot cells.
//
// Usage:
//   rec carries one signed 64-bit timestamp per transaction; res returns one
//   decision per record: accepted and the slot it was written to (slot 0 on
//   rejection). cfg_wr_en/cfg_wr_data write the capacity register (reset 16);
//   write it only while the block is idle. Capacity 0 acts as 1, anything
//   above 16 acts as 16.
// Flow:
//   One record is in flight at a time. While the store fills (or capacity is
//   1) a record's decision passes through the pending and output registers.
//   Once full, the oldest slot is found by a token that walks the row of 16
//   cells, one cell per cycle; then the decision is made, held in the pending
//   register and loaded into the output register.
// Reset:
//   rst clears the fill count, control state and output valid; slot contents
//   are left as they are and are never read before being written.
// Stall:
//   The output register holds a decision while res.ready is low; the next
//   record may be accepted meanwhile and its decision waits in a pending
//   register until the output frees up.
module newest_k_timestamp_sampler import nts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  cap_t             cfg_wr_data,
  nts_rec_if.sink          rec,
  nts_res_if.source        res
);

  state_t state, state_next;

  cap_t   capacity;
  cap_t   cap_eff;
  cap_t   fill_count, fill_count_next;
  logic   full;
  logic   rec_fire;

  stamp_t rec_time;
  logic   pend_acc, pend_acc_next;
  slot_t  pend_idx, pend_idx_next;
  logic   pend_load;

  logic   out_valid;
  logic   out_acc;
  slot_t  out_idx;
  logic   out_load;

  logic   start_tok;
  wr_t    wr;
  chain_t link [0:SLOT_COUNT];

  // Clamp capacity into 1..SLOT_COUNT.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = cap_t'(1);
    end else if (capacity > cap_t'(SLOT_COUNT)) begin
      cap_eff = cap_t'(SLOT_COUNT);
    end else begin
      cap_eff = capacity;
    end
  end

  assign full      = (fill_count >= cap_eff);
  assign rec.ready = (state == ST_IDLE);
  assign rec_fire  = rec.valid && rec.ready;

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    pend_load       = 1'b0;
    pend_acc_next   = 1'b0;
    pend_idx_next   = '0;
    start_tok       = 1'b0;
    out_load        = 1'b0;
    wr.en           = 1'b0;
    wr.idx          = fill_count[SLOT_W-1:0];
    wr.stamp        = rec.record_time;
    case (state)
      ST_IDLE: begin
        if (rec_fire) begin
          if (cap_eff == cap_t'(1)) begin
            // Single slot: always keep, store untouched.
            pend_load     = 1'b1;
            pend_acc_next = 1'b1;
            state_next    = ST_DONE;
          end else if (!full) begin
            // Fill the next free slot.
            wr.en           = 1'b1;
            fill_count_next = fill_count + cap_t'(1);
            pend_load       = 1'b1;
            pend_acc_next   = 1'b1;
            pend_idx_next   = fill_count[SLOT_W-1:0];
            state_next      = ST_DONE;
          end else begin
            // Launch the oldest-slot search down the cell row.
            start_tok  = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        wr.idx   = link[SLOT_COUNT].idx;
        wr.stamp = rec_time;
        if (link[SLOT_COUNT].tok) begin
          pend_load = 1'b1;
          if (rec_time > link[SLOT_COUNT].stamp) begin
            wr.en         = 1'b1;
            pend_acc_next = 1'b1;
            pend_idx_next = link[SLOT_COUNT].idx;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      fill_count <= fill_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold record and decisions, no reset needed.
  always_ff @(posedge clk) begin
    if (rec_fire) begin
      rec_time <= rec.record_time;
    end
    if (pend_load) begin
      pend_acc <= pend_acc_next;
      pend_idx <= pend_idx_next;
    end
    if (out_load) begin
      out_acc <= pend_acc;
      out_idx <= pend_idx;
    end
  end

  assign res.valid      = out_valid;
  assign res.accepted   = out_acc;
  assign res.slot_index = out_idx;

  // Head of the row: the token carries no candidate yet; cell 0 always takes its own.
  assign link[0].tok   = start_tok;
  assign link[0].stamp = '0;
  assign link[0].idx   = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    nts_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cap      (cap_eff),
      .wr       (wr),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

endmodule

@@ rtl/core/nts_checker.sv @@
// Port-level checker for the newest-k timestamp sampler, bound to the top level.
module nts_checker import nts_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  rec_valid,
  input logic  rec_ready,
  input logic  res_valid,
  input logic  res_ready,
  input logic  res_accepted,
  input slot_t res_slot_index
);

  // Reset empties the output.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // One record in flight: drop ready right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready |=> !rec_ready)
    else $error("input accepted back to back");

  // Rejections report slot zero.
  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_accepted |-> res_slot_index == '0)
    else $error("rejected record with nonzero slot");

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_accepted)
      && $stable(res_slot_index))
    else $error("stalled result changed");

endmodule

bind newest_k_timestamp_sampler nts_checker u_nts_checker (
  .clk            (clk),
  .rst            (rst),
  .rec_valid      (rec.valid),
  .rec_ready      (rec.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_accepted   (res.accepted),
  .res_slot_index (res.slot_index)
);
